FILE: rtl/fixed_point_alu_requantize_defines.svh
// assertion macros for the fixed-point alu requantize block
`ifndef FIXED_POINT_ALU_REQUANTIZE_DEFINES_SVH
`define FIXED_POINT_ALU_REQUANTIZE_DEFINES_SVH
`ifndef SYNTHESIS
`define FXREQ_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define FXREQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define FXREQ_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define FXREQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

FILE: rtl/fxreq_pkg.sv
// shared types for the fixed-point alu requantize pipeline
package fxreq_pkg;

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_SUB    = 2'd1,
        OP_MUL    = 2'd2,
        OP_RESIZE = 2'd3
    } t_op;

    // result format carried down the pipe
    typedef struct packed {
        logic [5:0] frac;
        logic [6:0] total;
    } t_fmt;

    // resize rounding controls from stage 1 to stage 2
    typedef struct packed {
        logic       right;
        logic       neg;
        logic [4:0] shift;
    } t_rsz;

endpackage

FILE: rtl/fxreq_arith.sv
// stage 1: add, subtract, multiply and resize preparation
module fxreq_arith (
    input  logic                i_clk,
    input  logic                i_en,
    input  fxreq_pkg::t_op      i_op,
    input  logic signed [31:0]  i_a_value,
    input  logic [4:0]          i_a_frac,
    input  logic [5:0]          i_a_total,
    input  logic signed [31:0]  i_b_value,
    input  logic [4:0]          i_b_frac,
    input  logic [5:0]          i_b_total,
    input  logic [5:0]          i_new_total,
    input  logic [4:0]          i_new_frac,
    output logic [63:0]         o_wide,
    output fxreq_pkg::t_rsz     o_rsz,
    output fxreq_pkg::t_fmt     o_fmt
);

    logic signed [63:0] a64;
    logic signed [63:0] b64;
    logic signed [63:0] prod;
    logic [4:0]         lsh;
    logic [4:0]         rsh;
    logic               right;
    logic [32:0]        mag;
    logic [32:0]        mag_half;
    logic [63:0]        n_wide;
    fxreq_pkg::t_rsz    n_rsz;
    fxreq_pkg::t_fmt    n_fmt;
    logic [63:0]        r_wide;
    fxreq_pkg::t_rsz    r_rsz;
    fxreq_pkg::t_fmt    r_fmt;

    assign a64   = 64'(i_a_value);
    assign b64   = 64'(i_b_value);
    // operands are sign-extended 32-bit values, so this is a 32 by 32 signed product
    assign prod  = a64 * b64;
    assign lsh   = i_new_frac - i_a_frac;
    assign rsh   = i_a_frac - i_new_frac;
    assign right = i_a_frac > i_new_frac;

    // magnitude plus half a unit of the last kept bit, shifted in stage 2
    assign mag      = i_a_value[31] ? 33'(-a64) : 33'(a64);
    assign mag_half = mag + (33'd1 << (rsh - 5'd1));

    always_comb begin
        n_fmt = '0;
        unique case (i_op)
            fxreq_pkg::OP_ADD: begin
                n_wide       = 64'(a64 + b64);
                n_fmt.frac   = {1'b0, i_a_frac};
                n_fmt.total  = {1'b0, i_a_total};
            end
            fxreq_pkg::OP_SUB: begin
                n_wide       = 64'(a64 - b64);
                n_fmt.frac   = {1'b0, i_a_frac};
                n_fmt.total  = {1'b0, i_a_total};
            end
            fxreq_pkg::OP_MUL: begin
                n_wide       = prod;
                n_fmt.frac   = 6'(i_a_frac) + 6'(i_b_frac);
                n_fmt.total  = 7'(i_a_total) + 7'(i_b_total);
            end
            fxreq_pkg::OP_RESIZE: begin
                n_wide       = right ? 64'(mag_half) : 64'(a64 <<< lsh);
                n_fmt.frac   = {1'b0, i_new_frac};
                n_fmt.total  = {1'b0, i_new_total};
            end
            default: begin
                n_wide       = '0;
            end
        endcase
    end

    always_comb begin
        n_rsz.right = (i_op == fxreq_pkg::OP_RESIZE) && right;
        n_rsz.neg   = i_a_value[31];
        n_rsz.shift = rsh;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_wide <= n_wide;
            r_rsz  <= n_rsz;
            r_fmt  <= n_fmt;
        end
    end

    assign o_wide = r_wide;
    assign o_rsz  = r_rsz;
    assign o_fmt  = r_fmt;

endmodule

FILE: rtl/fxreq_round.sv
// stage 2: resize right shift with rounding and wrap to the raw width
module fxreq_round #(
    parameter int RAW_WIDTH = 32
) (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [63:0]                 i_wide,
    input  fxreq_pkg::t_rsz             i_rsz,
    input  fxreq_pkg::t_fmt             i_fmt,
    output logic signed [RAW_WIDTH-1:0] o_raw,
    output fxreq_pkg::t_fmt             o_fmt
);

    logic [32:0]                 q;
    logic [63:0]                 mag64;
    logic [63:0]                 rounded;
    logic signed [RAW_WIDTH-1:0] n_raw;
    logic signed [RAW_WIDTH-1:0] r_raw;
    fxreq_pkg::t_fmt             r_fmt;

    assign q       = i_wide[32:0] >> i_rsz.shift;
    assign mag64   = 64'(q);
    assign rounded = i_rsz.neg ? (64'd0 - mag64) : mag64;
    assign n_raw   = RAW_WIDTH'(i_rsz.right ? rounded : i_wide);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_raw <= n_raw;
            r_fmt <= i_fmt;
        end
    end

    assign o_raw = r_raw;
    assign o_fmt = r_fmt;

endmodule

FILE: rtl/fxreq_sat.sv
// stage 3: wrap or saturate to the result total width (raw value kept if total >= raw width, zero if total is 0)
module fxreq_sat #(
    parameter int RAW_WIDTH = 32
) (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic                        i_overflow_mode,
    input  logic signed [RAW_WIDTH-1:0] i_raw,
    input  fxreq_pkg::t_fmt             i_fmt,
    output logic signed [31:0]          o_result_value,
    output fxreq_pkg::t_fmt             o_fmt
);

    localparam logic [6:0] RawTot = 7'(RAW_WIDTH);

    logic [6:0]                  sh;
    logic signed [RAW_WIDTH-1:0] up;
    logic signed [RAW_WIDTH-1:0] wrapped;
    logic signed [RAW_WIDTH-1:0] hi;
    logic signed [RAW_WIDTH-1:0] lo;
    logic signed [RAW_WIDTH-1:0] sat;
    logic signed [RAW_WIDTH-1:0] q;
    logic signed [63:0]          q64;
    logic signed [31:0]          r_value;
    fxreq_pkg::t_fmt             r_fmt;

    // sign extension from the total width by a shift up and back down
    assign sh      = RawTot - i_fmt.total;
    assign up      = i_raw <<< sh;
    assign wrapped = up >>> sh;

    assign hi  = (RAW_WIDTH'(1) << (i_fmt.total - 7'd1)) - RAW_WIDTH'(1);
    assign lo  = ~hi;
    assign sat = (i_raw > hi) ? hi : ((i_raw < lo) ? lo : i_raw);

    always_comb begin
        if (i_fmt.total == 7'd0) begin
            q = '0;
        end else if (i_fmt.total >= RawTot) begin
            q = i_raw;
        end else if (i_overflow_mode) begin
            q = sat;
        end else begin
            q = wrapped;
        end
    end

    assign q64 = 64'(q);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_value <= q64[31:0];
            r_fmt   <= i_fmt;
        end
    end

    assign o_result_value = r_value;
    assign o_fmt          = r_fmt;

endmodule

FILE: rtl/fixed_point_alu_requantize.sv
// top level of the fixed-point alu with requantization
// an accepted word passes through stage 1 (arith), stage 2 (round) and stage 3 (sat) to its result word at the output
// throughput: one word per cycle while i_stall is low; each of the three stages holds one word
// a stage refills as soon as its word moves on, so stalls lose nothing
// reset (synchronous, active low) empties the pipe and sets overflow mode to wrap
`include "fixed_point_alu_requantize_defines.svh"
module fixed_point_alu_requantize #(
    parameter int RAW_WIDTH = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_wr_en,
    input  logic                i_cfg_wr_data,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [1:0]          i_op,
    input  logic signed [31:0]  i_a_value,
    input  logic [4:0]          i_a_frac,
    input  logic [5:0]          i_a_total,
    input  logic signed [31:0]  i_b_value,
    input  logic [4:0]          i_b_frac,
    input  logic [5:0]          i_b_total,
    input  logic [5:0]          i_new_total,
    input  logic [4:0]          i_new_frac,
    output logic                o_valid,
    input  logic                i_stall,
    output logic signed [31:0]  o_result_value,
    output logic [5:0]          o_result_frac,
    output logic [6:0]          o_result_total
);

    logic                        r_overflow_mode;
    logic                        r_v1;
    logic                        r_v2;
    logic                        r_v3;
    logic                        rdy1;
    logic                        rdy2;
    logic                        rdy3;
    logic [63:0]                 s1_wide;
    fxreq_pkg::t_rsz             s1_rsz;
    fxreq_pkg::t_fmt             s1_fmt;
    logic signed [RAW_WIDTH-1:0] s2_raw;
    fxreq_pkg::t_fmt             s2_fmt;
    fxreq_pkg::t_fmt             s3_fmt;

    // a stage takes a new word when empty or when its word moves on
    assign rdy3 = !r_v3 || !i_stall;
    assign rdy2 = !r_v2 || rdy3;
    assign rdy1 = !r_v1 || rdy2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_overflow_mode <= 1'b0;
        end else if (i_cfg_wr_en) begin
            r_overflow_mode <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (rdy1) begin
                r_v1 <= i_valid;
            end
            if (rdy2) begin
                r_v2 <= r_v1;
            end
            if (rdy3) begin
                r_v3 <= r_v2;
            end
        end
    end

    fxreq_arith u_arith (
        .i_clk       (i_clk),
        .i_en        (rdy1),
        .i_op        (fxreq_pkg::t_op'(i_op)),
        .i_a_value   (i_a_value),
        .i_a_frac    (i_a_frac),
        .i_a_total   (i_a_total),
        .i_b_value   (i_b_value),
        .i_b_frac    (i_b_frac),
        .i_b_total   (i_b_total),
        .i_new_total (i_new_total),
        .i_new_frac  (i_new_frac),
        .o_wide      (s1_wide),
        .o_rsz       (s1_rsz),
        .o_fmt       (s1_fmt)
    );

    fxreq_round #(
        .RAW_WIDTH (RAW_WIDTH)
    ) u_round (
        .i_clk  (i_clk),
        .i_en   (rdy2),
        .i_wide (s1_wide),
        .i_rsz  (s1_rsz),
        .i_fmt  (s1_fmt),
        .o_raw  (s2_raw),
        .o_fmt  (s2_fmt)
    );

    fxreq_sat #(
        .RAW_WIDTH (RAW_WIDTH)
    ) u_sat (
        .i_clk           (i_clk),
        .i_en            (rdy3),
        .i_overflow_mode (r_overflow_mode),
        .i_raw           (s2_raw),
        .i_fmt           (s2_fmt),
        .o_result_value  (o_result_value),
        .o_fmt           (s3_fmt)
    );

    assign o_stall        = !rdy1;
    assign o_valid        = r_v3;
    assign o_result_frac  = s3_fmt.frac;
    assign o_result_total = s3_fmt.total;

    `FXREQ_ASSERT_IMPL(a_stall_only_full, i_clk, i_rst_n, o_stall, o_valid && i_stall && r_v1 && r_v2, "input stalled while the pipe has room")
    `FXREQ_ASSERT_NEXT(a_accept_loads, i_clk, i_rst_n, i_valid && !o_stall, r_v1, "accepted word did not enter stage 1")
    `FXREQ_ASSERT_NEXT(a_drain_empty, i_clk, i_rst_n, o_valid && !i_stall && !r_v2, !o_valid, "output word repeated after being taken")

endmodule
